@@ rtl/core/btt_pkg.sv @@
// ----------------------------------------------------------------------------
// btt_pkg
// Shared types and constants of the blocked twiddle and transpose pass.
// ----------------------------------------------------------------------------
`default_nettype none

package btt_pkg;

    localparam int SAMPLE_W = 16;
    localparam int CFG_W    = 13;
    localparam int ADDR_W   = 24;

    typedef enum logic [2:0] {
        CFG_ROW_COUNT    = 3'd0,
        CFG_COL_COUNT    = 3'd1,
        CFG_SRC_STRIDE   = 3'd2,
        CFG_DST_STRIDE   = 3'd3,
        CFG_INVERSE_MODE = 3'd4
    } cfg_index_t;

    // One accepted word on its way from the front to the arithmetic back end.
    typedef struct packed {
        logic                       inverse;
        logic                       last;
        logic signed [SAMPLE_W-1:0] twiddle_im;
        logic signed [SAMPLE_W-1:0] twiddle_re;
        logic signed [SAMPLE_W-1:0] sample_im;
        logic signed [SAMPLE_W-1:0] sample_re;
    } btt_item_t;

endpackage

`default_nettype wire

@@ rtl/core/blocked_twiddle_transpose.sv @@
// ----------------------------------------------------------------------------
// blocked_twiddle_transpose
// Twiddle multiply and transpose pass of a four-step FFT.
// ----------------------------------------------------------------------------
// The block takes one complex Q1.15 sample with its twiddle per clock and
// returns one word per clock, unless the FIFO is full or the output held:
// the rounded, saturated product together with its source and transposed
// destination addresses, with tlast on the final word of the blocked walk.
// The walk counters tag each word on entry, a four-word FIFO holds it, one
// stage forms the partial products and address products, and the output
// register adds, rounds and saturates. The FIFO lets the input keep flowing
// for a few words while the output is held. The user must write configuration
// only while no word is in flight; the block itself does not enforce it.
`default_nettype none

module blocked_twiddle_transpose
    import btt_pkg::*;
#(
    parameter int BLOCK_SIZE = 64,
    parameter int TILE_SIZE  = 4,
    parameter int MAX_DIM    = 4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // sample_re, sample_im, twiddle_re, twiddle_im
    input  wire logic [63:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // product_re, product_im, source_addr, dest_addr
    output logic [79:0]      m_axis_tdata,
    // pass_done
    output logic             m_axis_tlast,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [12:0] cfg_data
);

    localparam int CW      = $clog2(MAX_DIM + BLOCK_SIZE + TILE_SIZE + 1);
    localparam int Q_DEPTH = 4;
    localparam int Q_W     = $bits(btt_item_t) + 2 * CW;

    logic [CFG_W-1:0] row_count_reg, col_count_reg;
    logic [CFG_W-1:0] src_stride_reg, dst_stride_reg;
    logic             inverse_mode_reg;

    logic             take, q_full, q_not_empty, q_pop;
    logic [CW-1:0]    walk_row, walk_col;
    logic             walk_last;
    btt_item_t        push_item, pop_item;
    logic [CW-1:0]    pop_row, pop_col;
    logic [Q_W-1:0]   q_push_data, q_pop_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg    <= CFG_W'(64);
            col_count_reg    <= CFG_W'(64);
            src_stride_reg   <= CFG_W'(64);
            dst_stride_reg   <= CFG_W'(64);
            inverse_mode_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_ROW_COUNT:    row_count_reg    <= cfg_data;
                CFG_COL_COUNT:    col_count_reg    <= cfg_data;
                CFG_SRC_STRIDE:   src_stride_reg   <= cfg_data;
                CFG_DST_STRIDE:   dst_stride_reg   <= cfg_data;
                CFG_INVERSE_MODE: inverse_mode_reg <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign s_axis_tready = !q_full;
    assign take          = s_axis_tvalid && !q_full;

    btt_front #(
        .BLOCK_SIZE (BLOCK_SIZE),
        .TILE_SIZE  (TILE_SIZE),
        .MAX_DIM    (MAX_DIM),
        .CW         (CW)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .row_count (row_count_reg),
        .col_count (col_count_reg),
        .take      (take),
        .row       (walk_row),
        .col       (walk_col),
        .last      (walk_last)
    );

    always_comb begin
        push_item.inverse    = inverse_mode_reg;
        push_item.last       = walk_last;
        push_item.sample_re  = s_axis_tdata[15:0];
        push_item.sample_im  = s_axis_tdata[31:16];
        push_item.twiddle_re = s_axis_tdata[47:32];
        push_item.twiddle_im = s_axis_tdata[63:48];
    end

    assign q_push_data = {walk_col, walk_row, push_item};

    btt_queue #(
        .WIDTH (Q_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (take),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_pop_data)
    );

    assign {pop_col, pop_row, pop_item} = q_pop_data;

    logic back_ready;
    assign q_pop = q_not_empty && back_ready;

    btt_back #(
        .CW (CW)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .src_stride    (src_stride_reg),
        .dst_stride    (dst_stride_reg),
        .in_valid      (q_not_empty),
        .in_ready      (back_ready),
        .in_item       (pop_item),
        .in_row        (pop_row),
        .in_col        (pop_col),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

@@ rtl/core/btt_front.sv @@
// ----------------------------------------------------------------------------
// btt_front
// Walk generator: gives the row and column of the current word in blocked
// tile order and flags the last word of the pass.
// ----------------------------------------------------------------------------
`default_nettype none

module btt_front
    import btt_pkg::*;
#(
    parameter int BLOCK_SIZE = 64,
    parameter int TILE_SIZE  = 4,
    parameter int MAX_DIM    = 4096,
    parameter int CW         = 13
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [CFG_W-1:0] row_count,
    input  wire logic [CFG_W-1:0] col_count,
    input  wire logic             take,
    output logic      [CW-1:0]    row,
    output logic      [CW-1:0]    col,
    output logic                  last
);

    localparam int TW = (TILE_SIZE > 1) ? $clog2(TILE_SIZE) : 1;
    localparam logic [CW-1:0] BLOCK_STEP = CW'(BLOCK_SIZE);
    localparam logic [CW-1:0] TILE_STEP  = CW'(TILE_SIZE);
    localparam logic [TW-1:0] TILE_LAST  = TW'(TILE_SIZE - 1);

    logic [CW-1:0] col_block_base_reg, col_block_base_next;
    logic [CW-1:0] row_block_base_reg, row_block_base_next;
    logic [CW-1:0] tile_row_base_reg, tile_row_base_next;
    logic [CW-1:0] tile_col_base_reg, tile_col_base_next;
    logic [TW-1:0] in_tile_row_reg, in_tile_row_next;
    logic [TW-1:0] in_tile_col_reg, in_tile_col_next;

    logic [CW-1:0] n_rows, n_cols;
    logic [CW-1:0] col_end, row_end;
    logic [CW-1:0] col_block_step, row_block_step;
    logic [CW-1:0] tile_col_step, tile_row_step;
    logic          wrap;

    always_comb begin
        if (row_count == '0) begin
            n_rows = CW'(1);
        end else if (int'(row_count) > MAX_DIM) begin
            n_rows = CW'(MAX_DIM);
        end else begin
            n_rows = CW'(row_count);
        end
        if (col_count == '0) begin
            n_cols = CW'(1);
        end else if (int'(col_count) > MAX_DIM) begin
            n_cols = CW'(MAX_DIM);
        end else begin
            n_cols = CW'(col_count);
        end
    end

    assign col_block_step = col_block_base_reg + BLOCK_STEP;
    assign row_block_step = row_block_base_reg + BLOCK_STEP;
    assign tile_col_step  = tile_col_base_reg + TILE_STEP;
    assign tile_row_step  = tile_row_base_reg + TILE_STEP;
    assign col_end = (col_block_step < n_cols) ? col_block_step : n_cols;
    assign row_end = (row_block_step < n_rows) ? row_block_step : n_rows;

    always_comb begin
        col_block_base_next = col_block_base_reg;
        row_block_base_next = row_block_base_reg;
        tile_row_base_next  = tile_row_base_reg;
        tile_col_base_next  = tile_col_base_reg;
        in_tile_row_next    = in_tile_row_reg;
        in_tile_col_next    = in_tile_col_reg;
        wrap                = 1'b0;
        if (in_tile_col_reg == TILE_LAST) begin
            in_tile_col_next = '0;
            if (in_tile_row_reg == TILE_LAST) begin
                in_tile_row_next = '0;
                if (tile_col_step < col_end) begin
                    tile_col_base_next = tile_col_step;
                end else begin
                    tile_col_base_next = col_block_base_reg;
                    if (tile_row_step < row_end) begin
                        tile_row_base_next = tile_row_step;
                    end else if (row_block_step < n_rows) begin
                        row_block_base_next = row_block_step;
                        tile_row_base_next  = row_block_step;
                    end else begin
                        row_block_base_next = '0;
                        tile_row_base_next  = '0;
                        if (col_block_step < n_cols) begin
                            col_block_base_next = col_block_step;
                            tile_col_base_next  = col_block_step;
                        end else begin
                            col_block_base_next = '0;
                            tile_col_base_next  = '0;
                            wrap                = 1'b1;
                        end
                    end
                end
            end else begin
                in_tile_row_next = in_tile_row_reg + TW'(1);
            end
        end else begin
            in_tile_col_next = in_tile_col_reg + TW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_block_base_reg <= '0;
            row_block_base_reg <= '0;
            tile_row_base_reg  <= '0;
            tile_col_base_reg  <= '0;
            in_tile_row_reg    <= '0;
            in_tile_col_reg    <= '0;
        end else if (take) begin
            col_block_base_reg <= col_block_base_next;
            row_block_base_reg <= row_block_base_next;
            tile_row_base_reg  <= tile_row_base_next;
            tile_col_base_reg  <= tile_col_base_next;
            in_tile_row_reg    <= in_tile_row_next;
            in_tile_col_reg    <= in_tile_col_next;
        end
    end

    assign row  = tile_row_base_reg + CW'(in_tile_row_reg);
    assign col  = tile_col_base_reg + CW'(in_tile_col_reg);
    assign last = wrap;

endmodule

`default_nettype wire

@@ rtl/core/btt_queue.sv @@
// ----------------------------------------------------------------------------
// btt_queue
// Small synchronous FIFO between the walk front end and the arithmetic back.
// ----------------------------------------------------------------------------
`default_nettype none

module btt_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  not_empty,
    output logic      [WIDTH-1:0] pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [NW-1:0]    count_reg;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        bump = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + NW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - NW'(1);
            end
        end
    end

    assign full      = (count_reg == NW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

endmodule

`default_nettype wire

@@ rtl/core/btt_back.sv @@
// ----------------------------------------------------------------------------
// btt_back
// Complex multiply with rounding and saturation, and address computation,
// in two pipeline stages ending in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module btt_back
    import btt_pkg::*;
#(
    parameter int CW = 13
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [CFG_W-1:0]  src_stride,
    input  wire logic [CFG_W-1:0]  dst_stride,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire btt_item_t         in_item,
    input  wire logic [CW-1:0]     in_row,
    input  wire logic [CW-1:0]     in_col,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // product_re, product_im, source_addr, dest_addr
    output logic [2*SAMPLE_W+2*ADDR_W-1:0] m_axis_tdata,
    // pass_done
    output logic                   m_axis_tlast
);

    localparam int PROD_W = 2 * SAMPLE_W;
    localparam int AW     = CW + CFG_W;

    logic                     s1_valid_reg;
    logic signed [PROD_W-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic [AW-1:0]            src_prod_reg, dst_prod_reg;
    logic [CW-1:0]            s1_row_reg, s1_col_reg;
    logic                     s1_inverse_reg, s1_last_reg;

    logic                     out_valid_reg;
    logic [SAMPLE_W-1:0]      out_re_reg, out_im_reg;
    logic [ADDR_W-1:0]        out_src_reg, out_dst_reg;
    logic                     out_last_reg;

    logic                     out_free, s1_en;
    logic signed [PROD_W:0]   sum_re, sum_im;
    logic [SAMPLE_W-1:0]      prod_re_next, prod_im_next;

    function automatic logic [SAMPLE_W-1:0] round_sat(input logic signed [PROD_W:0] s);
        logic signed [PROD_W+1:0] v;
        logic signed [PROD_W+1:0] q;
        v = (PROD_W+2)'(s) + (PROD_W+2)'(1 << (SAMPLE_W - 2));
        q = v >>> (SAMPLE_W - 1);
        if (q > (PROD_W+2)'(32767)) begin
            round_sat = 16'h7fff;
        end else if (q < -(PROD_W+2)'(32768)) begin
            round_sat = 16'h8000;
        end else begin
            round_sat = q[SAMPLE_W-1:0];
        end
    endfunction

    assign out_free = !out_valid_reg || m_axis_tready;
    assign s1_en    = !s1_valid_reg || out_free;
    assign in_ready = s1_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_en) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_en && in_valid) begin
            p_rr_reg       <= in_item.sample_re * in_item.twiddle_re;
            p_ii_reg       <= in_item.sample_im * in_item.twiddle_im;
            p_ri_reg       <= in_item.sample_re * in_item.twiddle_im;
            p_ir_reg       <= in_item.sample_im * in_item.twiddle_re;
            src_prod_reg   <= AW'(in_row) * AW'(src_stride);
            dst_prod_reg   <= AW'(in_col) * AW'(dst_stride);
            s1_row_reg     <= in_row;
            s1_col_reg     <= in_col;
            s1_inverse_reg <= in_item.inverse;
            s1_last_reg    <= in_item.last;
        end
    end

    always_comb begin
        if (s1_inverse_reg) begin
            sum_re = (PROD_W+1)'(p_rr_reg) + (PROD_W+1)'(p_ii_reg);
            sum_im = (PROD_W+1)'(p_ir_reg) - (PROD_W+1)'(p_ri_reg);
        end else begin
            sum_re = (PROD_W+1)'(p_rr_reg) - (PROD_W+1)'(p_ii_reg);
            sum_im = (PROD_W+1)'(p_ri_reg) + (PROD_W+1)'(p_ir_reg);
        end
        prod_re_next = round_sat(sum_re);
        prod_im_next = round_sat(sum_im);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && s1_valid_reg) begin
            out_re_reg   <= prod_re_next;
            out_im_reg   <= prod_im_next;
            out_src_reg  <= ADDR_W'(src_prod_reg) + ADDR_W'(s1_col_reg);
            out_dst_reg  <= ADDR_W'(dst_prod_reg) + ADDR_W'(s1_row_reg);
            out_last_reg <= s1_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_dst_reg, out_src_reg, out_im_reg, out_re_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

@@ rtl/core/btt_checker.sv @@
// ----------------------------------------------------------------------------
// btt_checker
// Port-level checks of the twiddle and transpose block, bound to its top.
// ----------------------------------------------------------------------------
`default_nettype none

module btt_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [79:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);

    // A held result word keeps its valid.
    a_out_valid_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    // A held result word keeps its payload.
    a_out_data_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result word changed while stalled");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result word valid right after reset");

    // Reset empties the FIFO, so input is taken at once.
    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_axis_tready)
        else $error("input not ready right after reset");

endmodule

bind blocked_twiddle_transpose btt_checker u_btt_checker (.*);

`default_nettype wire

@@ dv/blocked_twiddle_transpose_test.sv @@
// ----------------------------------------------------------------------------
// blocked_twiddle_transpose_test
// Self-checking testbench of the twiddle multiply and transpose pass.
// ----------------------------------------------------------------------------
// Every accepted input word is run through a local model of the blocked walk
// and the Q1.15 complex multiply. The model's word is queued, and each output
// word is compared field by field with the oldest queued one. Named tests
// cover reset settings, inverse mode with rounding and saturation corners,
// clamped dimensions and zero strides, large addresses on both sides, and
// random traffic under several idle and stall patterns with settings changed
// between phases.
module blocked_twiddle_transpose_test
    import btt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BLOCK        = 64;
    localparam int TILE         = 4;
    localparam int DIM_LIMIT    = 4096;
    localparam int PIPE_DEPTH   = 8;
    localparam int STALL_LIMIT  = 4000;
    localparam int REPORT_LIMIT = 10;
    localparam int BUSY_PCT     = 85;
    localparam int LIGHT_PCT    = 12;
    localparam logic [2:0] CFG_SPARE_FIRST = CFG_INVERSE_MODE + 3'd1;
    localparam logic [2:0] CFG_SPARE_LAST  = 3'b111;

    typedef struct packed {
        logic                       pass_done;
        logic [ADDR_W-1:0]          dest_addr;
        logic [ADDR_W-1:0]          source_addr;
        logic signed [SAMPLE_W-1:0] product_im;
        logic signed [SAMPLE_W-1:0] product_re;
    } twiddled_t;

    logic        aclk;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_we        = 1'b0;
    logic [2:0]  cfg_index     = '0;
    logic [12:0] cfg_data      = '0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int stall_cycles   = 0;

    twiddled_t pending_products[$];

    // Shadow of the register file and of the walk position.
    int unsigned rows_reg    = 64;
    int unsigned cols_reg    = 64;
    int unsigned src_pitch   = 64;
    int unsigned dst_pitch   = 64;
    bit          conj_mode   = 1'b0;
    int unsigned col_blk     = 0;
    int unsigned row_blk     = 0;
    int unsigned tile_row    = 0;
    int unsigned tile_col    = 0;
    int unsigned sub_row     = 0;
    int unsigned sub_col     = 0;

    blocked_twiddle_transpose #(
        .BLOCK_SIZE(BLOCK),
        .TILE_SIZE (TILE),
        .MAX_DIM   (DIM_LIMIT)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned clamp_dim(input int unsigned v);
        if (v < 1) return 1;
        if (v > DIM_LIMIT) return DIM_LIMIT;
        return v;
    endfunction

    function automatic int unsigned block_end(input int unsigned base, input int unsigned dim);
        return (base + BLOCK < dim) ? base + BLOCK : dim;
    endfunction

    // Steps the walk by one word; returns 1 when it wraps back to its start.
    function automatic bit walk_advance();
        int unsigned nr;
        int unsigned nc;
        nr = clamp_dim(rows_reg);
        nc = clamp_dim(cols_reg);
        sub_col++;
        if (sub_col < TILE) return 1'b0;
        sub_col = 0;
        sub_row++;
        if (sub_row < TILE) return 1'b0;
        sub_row = 0;
        tile_col += TILE;
        if (tile_col < block_end(col_blk, nc)) return 1'b0;
        tile_col = col_blk;
        tile_row += TILE;
        if (tile_row < block_end(row_blk, nr)) return 1'b0;
        row_blk += BLOCK;
        if (row_blk < nr) begin
            tile_row = row_blk;
            return 1'b0;
        end
        row_blk  = 0;
        tile_row = 0;
        col_blk += BLOCK;
        if (col_blk < nc) begin
            tile_col = col_blk;
            return 1'b0;
        end
        col_blk  = 0;
        tile_col = 0;
        return 1'b1;
    endfunction

    function automatic logic [SAMPLE_W-1:0] round_q15(input longint sum);
        longint q;
        q = (sum + 64'sd16384) >>> 15;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[SAMPLE_W-1:0];
    endfunction

    task automatic predict_twiddled(input logic [63:0] word);
        longint      sr;
        longint      si;
        longint      tr;
        longint      ti;
        longint      pr;
        longint      pi;
        longint unsigned row;
        longint unsigned col;
        twiddled_t   want;
        sr  = longint'($signed(word[15:0]));
        si  = longint'($signed(word[31:16]));
        tr  = longint'($signed(word[47:32]));
        ti  = longint'($signed(word[63:48]));
        row = tile_row + sub_row;
        col = tile_col + sub_col;
        if (conj_mode) begin
            pr = sr * tr + si * ti;
            pi = si * tr - sr * ti;
        end else begin
            pr = sr * tr - si * ti;
            pi = sr * ti + si * tr;
        end
        want.product_re  = round_q15(pr);
        want.product_im  = round_q15(pi);
        want.source_addr = ADDR_W'(row * src_pitch + col);
        want.dest_addr   = ADDR_W'(col * dst_pitch + row);
        want.pass_done   = walk_advance();
        pending_products.push_back(want);
    endtask

    task automatic report_mismatch(input bit unexpected, input twiddled_t want,
                                   input twiddled_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            if (unexpected) begin
                $display("unexpected word: re %0d im %0d src %0d dst %0d last %0b",
                         got.product_re, got.product_im, got.source_addr,
                         got.dest_addr, got.pass_done);
            end else begin
                $display("mismatch: expected re %0d im %0d src %0d dst %0d last %0b",
                         want.product_re, want.product_im, want.source_addr,
                         want.dest_addr, want.pass_done);
                $display("          actual   re %0d im %0d src %0d dst %0d last %0b",
                         got.product_re, got.product_im, got.source_addr,
                         got.dest_addr, got.pass_done);
            end
        end
    endtask

    always @(posedge aclk) begin : track
        twiddled_t got;
        twiddled_t want;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tlast, m_axis_tdata};
                if (pending_products.size() == 0) begin
                    report_mismatch(1'b1, got, got);
                end else begin
                    want = pending_products.pop_front();
                    if (got !== want) report_mismatch(1'b0, want, got);
                end
            end
            if (s_axis_tvalid && s_axis_tready) predict_twiddled(s_axis_tdata);
            if (cfg_we) begin
                case (cfg_index)
                    CFG_ROW_COUNT:    rows_reg  = cfg_data;
                    CFG_COL_COUNT:    cols_reg  = cfg_data;
                    CFG_SRC_STRIDE:   src_pitch = cfg_data;
                    CFG_DST_STRIDE:   dst_pitch = cfg_data;
                    CFG_INVERSE_MODE: conj_mode = cfg_data[0];
                    default: ;
                endcase
            end
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) || cfg_we)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge aclk);
        $display("simulation failed");
        $finish;
    end

    task automatic send_word(input logic [63:0] word);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_products.size() != 0) @(posedge aclk);
        repeat (PIPE_DEPTH) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [12:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
    endtask

    task automatic program_block(input logic [12:0] rows, input logic [12:0] cols,
                                 input logic [12:0] src_step, input logic [12:0] dst_step,
                                 input logic inv);
        wait_drained();
        write_reg(CFG_ROW_COUNT, rows);
        write_reg(CFG_COL_COUNT, cols);
        write_reg(CFG_SRC_STRIDE, src_step);
        write_reg(CFG_DST_STRIDE, dst_step);
        write_reg(CFG_INVERSE_MODE, {12'($urandom), inv});
        write_reg(3'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)), 13'($urandom));
        cfg_we <= 1'b0;
    endtask

    function automatic logic [63:0] pack_word(input int sr, input int si,
                                              input int tr, input int ti);
        return {16'(ti), 16'(tr), 16'(si), 16'(sr)};
    endfunction

    function automatic logic [15:0] random_part();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [12:0] random_dim();
        case ($urandom_range(0, 11))
            0: return 13'd0;
            1: return 13'd1;
            2: return 13'(DIM_LIMIT);
            3: return 13'h1fff;
            4, 5: return 13'($urandom_range(60, 70));
            default: return 13'($urandom_range(1, 24));
        endcase
    endfunction

    function automatic logic [12:0] random_stride();
        case ($urandom_range(0, 4))
            0: return 13'd0;
            1: return 13'h1fff;
            2: return 13'($urandom);
            default: return 13'($urandom_range(1, 80));
        endcase
    endfunction

    task automatic send_corner_words();
        send_word(pack_word(32767, 32767, 32767, 32767));
        send_word(pack_word(-32768, -32768, -32768, -32768));
        send_word(pack_word(-32768, -32768, -32768, 32767));
        send_word(pack_word(-32768, 32767, 32767, 32767));
        send_word(pack_word(32767, -32768, 32767, -32768));
        send_word(pack_word(1, 0, 16384, 0));
        send_word(pack_word(-1, 0, 16384, 0));
        send_word(pack_word(0, 1, 0, 16384));
        send_word(pack_word(0, 0, 0, 0));
        send_word(pack_word(-1, -1, -1, -1));
        send_word(pack_word(12345, -23456, 32767, 0));
        send_word(pack_word(3, 16384, -16384, 3));
    endtask

    task automatic test_reset_settings();
        send_corner_words();
    endtask

    task automatic test_inverse_mode();
        program_block(13'd64, 13'd64, 13'd64, 13'd64, 1'b1);
        send_corner_words();
    endtask

    task automatic test_dimension_limits();
        program_block(13'd0, 13'd0, 13'd0, 13'd0, 1'b0);
        repeat (40) send_word({random_part(), random_part(), random_part(), random_part()});
        program_block(13'd1, 13'd5, 13'h1fff, 13'd3, 1'b1);
        repeat (70) send_word({random_part(), random_part(), random_part(), random_part()});
    endtask

    // A tall, narrow matrix and a wide, flat one with the widest strides give
    // large source and transposed addresses.
    task automatic test_address_wrap();
        program_block(13'h1fff, 13'd1, 13'h1fff, 13'd0, 1'b0);
        repeat (40) send_word({random_part(), random_part(), random_part(), random_part()});
        program_block(13'd1, 13'h1fff, 13'd0, 13'h1fff, 1'b1);
        repeat (40) send_word({random_part(), random_part(), random_part(), random_part()});
    endtask

    task automatic test_random_traffic();
        int mode;
        int setting;
        int n;
        for (mode = 0; mode < 4; mode++) begin
            send_idle_pct  = (mode == 1) ? BUSY_PCT : (mode == 3) ? LIGHT_PCT : 0;
            recv_stall_pct = (mode == 2) ? BUSY_PCT : (mode == 3) ? LIGHT_PCT : 0;
            for (setting = 0; setting < 3; setting++) begin
                program_block(random_dim(), random_dim(), random_stride(), random_stride(),
                              1'($urandom));
                for (n = 0; n < 96; n++) begin
                    send_word({random_part(), random_part(), random_part(), random_part()});
                    if (setting == 1 && n == 48) wait_drained();
                end
            end
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_settings();
        test_inverse_mode();
        test_dimension_limits();
        test_address_wrap();
        test_random_traffic();
        wait_drained();
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
